// ===== src/dst_pkg.sv =====
// ---------------------------------------------------------------------------
// dst_pkg
// Shared types and constants for the separator tokenizer.
// ---------------------------------------------------------------------------
package dst_pkg;

    localparam int BYTE_W         = 8;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 3;
    localparam int MASK_COUNT     = 4;
    localparam int WIDE_W         = 16;
    localparam int WIDE_REG_COUNT = 2;
    localparam int WIDE_SEP_COUNT = 2;
    localparam int SLOT_COUNT     = 3;
    localparam int SLOT_IDX_W     = 2;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEP_MASK_0 = 3'd0,
        CFG_SEP_MASK_1 = 3'd1,
        CFG_SEP_MASK_2 = 3'd2,
        CFG_SEP_MASK_3 = 3'd3,
        CFG_WIDE_SEP_A = 3'd4,
        CFG_WIDE_SEP_B = 3'd5,
        CFG_SKIP_EMPTY = 3'd6
    } t_cfg_index;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_TOK_END = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               fin;
        logic [BYTE_W-1:0]  data;
    } t_slot;

    typedef struct packed {
        t_slot [SLOT_COUNT-1:0] slots;
        logic  [SLOT_IDX_W-1:0] last_idx;
    } t_cmd;

    function automatic logic is_lead(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
    endfunction

endpackage

// ===== src/dbcs_separator_tokenizer_core.sv =====
// ---------------------------------------------------------------------------
// dbcs_separator_tokenizer_core
// Splits a Shift-JIS byte stream into tokens at separator characters.
//
// Input stream: one string byte per item in s_axis_tdata, tlast on the
// final byte of a string. Output stream: token bytes (tuser kind 0) and
// end-of-token markers (tuser kind 1, final flag set on the marker closing
// the string); tlast marks the last result produced by one input byte.
// Configuration: write i_cfg_index/i_cfg_data with i_cfg_valid while idle;
// o_cfg_ready is always high. Indexes 0..3 separator masks, 4..5 double-byte
// separators, 6 skip-empty.
//
// Path: a byte is classified into the command queue when it is accepted,
// then loaded into the output register when the output sequencer takes its
// command from the queue.
// Throughput: one byte per cycle while the receiver is ready and each byte
// yields at most one result; a byte yielding several results holds the single
// output port until all are sent. A held lead byte yields nothing.
// A four-entry command queue absorbs bursts; when the receiver stalls the
// queue fills and s_axis_tready drops. Reset clears the queue, the output
// register, the lead-byte state and all configuration registers.
// ---------------------------------------------------------------------------
module dbcs_separator_tokenizer_core #(
    parameter int WIDE_SEP_COUNT = dst_pkg::WIDE_SEP_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dst_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                      m_axis_tuser,  // [0] out_kind, [1] out_final
    output logic                            m_axis_tlast
);
    import dst_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;

    dst_front #(
        .WIDE_SEP_COUNT (WIDE_SEP_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (q_push),
        .o_cmd       (push_cmd)
    );

    dst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    dst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_kind    (m_axis_tuser[0]),
        .o_final   (m_axis_tuser[1]),
        .o_run_end (m_axis_tlast)
    );

endmodule

// ===== src/dst_front.sv =====
// ---------------------------------------------------------------------------
// dst_front
// Accepts bytes, pairs lead bytes, classifies separators and builds the
// list of results for each byte. Holds the configuration registers.
// ---------------------------------------------------------------------------
module dst_front #(
    parameter int WIDE_SEP_COUNT = dst_pkg::WIDE_SEP_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [dst_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    input  logic [dst_pkg::BYTE_W-1:0]      i_byte,
    input  logic                            i_last,
    input  logic                            i_q_full,
    output logic                            o_ready,
    output logic                            o_push,
    output dst_pkg::t_cmd                   o_cmd
);
    import dst_pkg::*;

    logic [CFG_DATA_W-1:0] r_sep_mask [MASK_COUNT];
    logic [WIDE_W-1:0]     r_wide_sep [WIDE_REG_COUNT];
    logic                  r_skip_empty;

    logic                  r_lead_pending, n_lead_pending;
    logic [BYTE_W-1:0]     r_held_lead, n_held_lead;
    logic                  r_token_empty, n_token_empty;

    logic                  accept;
    logic [WIDE_W-1:0]     pair;
    logic                  wide_hit;
    logic                  single_hit;
    t_slot [SLOT_COUNT-1:0] slots;
    logic [SLOT_IDX_W:0]   cnt;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign pair    = {r_held_lead, i_byte};
    assign single_hit = r_sep_mask[i_byte[7:6]][i_byte[5:0]];

    always_comb begin
        wide_hit = 1'b0;
        for (int i = 0; i < WIDE_REG_COUNT; i++) begin
            if ((i < WIDE_SEP_COUNT) && (pair != '0) && (pair == r_wide_sep[i])) begin
                wide_hit = 1'b1;
            end
        end
    end

    always_comb begin
        slots          = '0;
        cnt            = '0;
        n_lead_pending = r_lead_pending;
        n_held_lead    = r_held_lead;
        n_token_empty  = r_token_empty;

        if (r_lead_pending) begin
            n_lead_pending = 1'b0;
            n_held_lead    = '0;
            if (wide_hit) begin
                if (!(r_token_empty && r_skip_empty)) begin
                    slots[0].kind = KIND_TOK_END;
                    cnt           = 3'd1;
                end
                n_token_empty = 1'b1;
            end else begin
                slots[0].data = r_held_lead;
                slots[1].data = i_byte;
                cnt           = 3'd2;
                n_token_empty = 1'b0;
            end
        end else if (is_lead(i_byte)) begin
            if (i_last) begin
                slots[0].data = i_byte;
                cnt           = 3'd1;
                n_token_empty = 1'b0;
            end else begin
                n_lead_pending = 1'b1;
                n_held_lead    = i_byte;
            end
        end else if (single_hit) begin
            if (!(r_token_empty && r_skip_empty)) begin
                slots[0].kind = KIND_TOK_END;
                cnt           = 3'd1;
            end
            n_token_empty = 1'b1;
        end else begin
            slots[0].data = i_byte;
            cnt           = 3'd1;
            n_token_empty = 1'b0;
        end

        if (i_last) begin
            slots[cnt[SLOT_IDX_W-1:0]].kind = KIND_TOK_END;
            slots[cnt[SLOT_IDX_W-1:0]].fin  = 1'b1;
            slots[cnt[SLOT_IDX_W-1:0]].data = '0;
            cnt            = cnt + 3'd1;
            n_lead_pending = 1'b0;
            n_held_lead    = '0;
            n_token_empty  = 1'b1;
        end
    end

    assign o_push         = accept && (cnt != '0);
    assign o_cmd.slots    = slots;
    assign o_cmd.last_idx = SLOT_IDX_W'(cnt - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pending <= 1'b0;
            r_held_lead    <= '0;
            r_token_empty  <= 1'b1;
        end else if (accept) begin
            r_lead_pending <= n_lead_pending;
            r_held_lead    <= n_held_lead;
            r_token_empty  <= n_token_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MASK_COUNT; i++) begin
                r_sep_mask[i] <= '0;
            end
            for (int i = 0; i < WIDE_REG_COUNT; i++) begin
                r_wide_sep[i] <= '0;
            end
            r_skip_empty <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SEP_MASK_0: r_sep_mask[0] <= i_cfg_data;
                CFG_SEP_MASK_1: r_sep_mask[1] <= i_cfg_data;
                CFG_SEP_MASK_2: r_sep_mask[2] <= i_cfg_data;
                CFG_SEP_MASK_3: r_sep_mask[3] <= i_cfg_data;
                CFG_WIDE_SEP_A: r_wide_sep[0] <= i_cfg_data[WIDE_W-1:0];
                CFG_WIDE_SEP_B: r_wide_sep[1] <= i_cfg_data[WIDE_W-1:0];
                CFG_SKIP_EMPTY: r_skip_empty  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== src/dst_queue.sv =====
// ---------------------------------------------------------------------------
// dst_queue
// Short command queue between the classifier and the output sequencer.
// ---------------------------------------------------------------------------
module dst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dst_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output dst_pkg::t_cmd o_cmd
);
    import dst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/dst_back.sv =====
// ---------------------------------------------------------------------------
// dst_back
// Output sequencer: holds one command; sends one result per cycle while ready.
// ---------------------------------------------------------------------------
module dst_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  dst_pkg::t_cmd               i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dst_pkg::BYTE_W-1:0]  o_byte,
    output logic                        o_kind,
    output logic                        o_final,
    output logic                        o_run_end
);
    import dst_pkg::*;

    logic                  r_valid;
    t_cmd                  r_cmd;
    logic [SLOT_IDX_W-1:0] r_idx;
    logic                  at_last;
    logic                  take;
    t_slot                 cur;

    assign cur       = r_cmd.slots[r_idx];
    assign at_last   = (r_idx == r_cmd.last_idx);
    assign take      = !r_valid || (i_ready && at_last);
    assign o_q_pop   = take;
    assign o_valid   = r_valid;
    assign o_byte    = cur.data;
    assign o_kind    = cur.kind;
    assign o_final   = cur.fin;
    assign o_run_end = at_last;

    always_ff @(posedge i_clk) begin
        if (take && i_q_valid) begin
            r_cmd <= i_q_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_valid <= i_q_valid;
            r_idx   <= '0;
        end else if (i_ready) begin
            r_idx   <= r_idx + 1'b1;
        end
    end

endmodule
